// ----- rtl/kabf_pkg.sv -----
// ----------------------------------------------------------------------------
// kabf_pkg
// Types, constants and helpers for the two-state angle/bias Kalman filter.
// ----------------------------------------------------------------------------
package kabf_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int WORD_WIDTH_DEF = 32;
    localparam int CFG_W          = 23;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 2'd2;

    localparam logic [CFG_W-1:0] ANGLE_NOISE_RST = 23'd66;
    localparam logic [CFG_W-1:0] BIAS_NOISE_RST  = 23'd197;
    localparam logic [CFG_W-1:0] MEAS_NOISE_RST  = 23'd1966;

    typedef struct packed {
        logic signed [24:0] measured_angle;
        logic signed [27:0] measured_rate;
        logic        [15:0] time_step;
    } kabf_in_t;

    typedef struct packed {
        logic signed [31:0] filtered_angle;
        logic signed [31:0] rate_bias;
    } kabf_out_t;

    // datapath operations, one per controller step
    typedef enum logic [4:0] {
        OP_LOAD,      // latch inputs, dt, rate = rate_in - bias
        OP_PRED,      // t = dt*rate
        OP_PRED2,     // pred = angle + t ; d = dt*p11
        OP_P00A,      // t = d - p01 - p10 + qa
        OP_P00B,      // t = dt*t
        OP_P00C,      // p00 += t; p01 -= d; p10 -= d; t = qb*dt
        OP_P11,       // p11 += t; s = p00 + rn
        OP_DIV0,      // start k0 = p00/s
        OP_DIV1,      // start k1 = p10/s
        OP_Y,         // y = meas - pred
        OP_ANG,       // t = k0*y
        OP_ANG2,      // angle = pred + t; t = k1*y
        OP_BIAS,      // bias += t; t = k0*p00
        OP_C00,       // n00 = p00 - t; t = k0*p01
        OP_C01,       // n01 = p01 - t; t = k1*p00
        OP_C10,       // n10 = p10 - t; t = k1*p01
        OP_C11        // p11 -= t; commit covariance
    } kabf_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIV_WAIT,
        ST_OUT
    } kabf_state_t;

    typedef struct packed {
        logic     op_valid;
        kabf_op_t op;
        logic     div_start;
        logic     out_load;
    } kabf_cmd_t;

    typedef struct packed {
        logic div_busy;
    } kabf_status_t;

endpackage

// ----- rtl/kabf_divider.sv -----
// ----------------------------------------------------------------------------
// kabf_divider
// Restoring divider, one quotient bit per cycle, saturating signed result.
// ----------------------------------------------------------------------------
module kabf_divider
    import kabf_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [WORD_WIDTH-1:0] num,
    input  logic signed [WORD_WIDTH-1:0] den,
    output logic                         busy,
    output logic                         done,
    output logic signed [WORD_WIDTH-1:0] quot
);
    localparam int STEPS = WORD_WIDTH + FRAC_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam logic [WORD_WIDTH:0] LIM_POS = {2'b00, {(WORD_WIDTH-1){1'b1}}};
    localparam logic [WORD_WIDTH:0] LIM_NEG = {2'b01, {(WORD_WIDTH-1){1'b0}}};

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next, done_reg, done_next;
    logic                  neg_reg, neg_next, sat_reg, sat_next;
    logic [STEPS-1:0]      shf_reg, shf_next;
    logic [WORD_WIDTH:0]   rem_reg, rem_next;
    logic [WORD_WIDTH-1:0] dmag_reg, dmag_next;
    logic [WORD_WIDTH:0]   q_reg, q_next;
    logic [WORD_WIDTH-1:0] nmag, dmag;
    logic [WORD_WIDTH+1:0] r_sh;
    logic [WORD_WIDTH+1:0] q_sh;
    logic [WORD_WIDTH:0]   lim, res_mag;
    logic [WORD_WIDTH:0]   signed_res;

    assign nmag = num[WORD_WIDTH-1] ? WORD_WIDTH'(-num) : WORD_WIDTH'(num);
    assign dmag = den[WORD_WIDTH-1] ? WORD_WIDTH'(-den) : WORD_WIDTH'(den);

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        sat_next  = sat_reg;
        shf_next  = shf_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        q_next    = q_reg;
        r_sh      = {rem_reg, shf_reg[STEPS-1]};
        q_sh      = {q_reg, 1'b0};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS);
            neg_next  = num[WORD_WIDTH-1] ^ den[WORD_WIDTH-1];
            sat_next  = (dmag == '0);
            shf_next  = {nmag, {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            dmag_next = dmag;
            q_next    = '0;
        end else if (busy_reg) begin
            shf_next = {shf_reg[STEPS-2:0], 1'b0};
            if (r_sh >= {2'b00, dmag_reg}) begin
                r_sh    = r_sh - {2'b00, dmag_reg};
                q_sh[0] = 1'b1;
            end
            rem_next = r_sh[WORD_WIDTH:0];
            if (q_sh > {1'b0, LIM_NEG}) begin
                sat_next = 1'b1;
                q_next   = LIM_NEG;
            end else begin
                q_next = q_sh[WORD_WIDTH:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg  <= neg_next;
        sat_reg  <= sat_next;
        shf_reg  <= shf_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        q_reg    <= q_next;
    end

    // zero divisor marks sat but gives zero, as does a zero quotient
    always_comb begin
        lim = neg_reg ? LIM_NEG : LIM_POS;
        if (dmag_reg == '0) begin
            res_mag = '0;
        end else if (sat_reg || q_reg > lim) begin
            res_mag = lim;
        end else begin
            res_mag = q_reg;
        end
        signed_res = neg_reg ? -res_mag : res_mag;
    end

    assign quot = signed_res[WORD_WIDTH-1:0];
    assign busy = busy_reg;
    assign done = done_reg;
endmodule

// ----- rtl/kabf_datapath.sv -----
// ----------------------------------------------------------------------------
// kabf_datapath
// Filter state, shared saturating multiplier, saturating add/subtract, divider.
// ----------------------------------------------------------------------------
module kabf_datapath
    import kabf_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  kabf_cmd_t    cmd,
    output kabf_status_t status,
    input  kabf_in_t     in_item,
    input  logic [CFG_W-1:0] qa_cfg,
    input  logic [CFG_W-1:0] qb_cfg,
    input  logic [CFG_W-1:0] rn_cfg,
    output kabf_out_t    out_item
);
    localparam int W  = WORD_WIDTH;
    localparam int PW = 2 * W;
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    typedef logic signed [W-1:0] word_t;

    word_t angle_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    word_t meas_reg, dt_reg, rate_reg, pred_reg, d_reg, t_reg, s_reg;
    word_t k0_reg, k1_reg, y_reg, n00_reg, n01_reg, n10_reg;
    word_t qa, qb, rn, meas_in, rate_in, dt_in;
    word_t mul_a, mul_b, mul_r;
    word_t div_num, div_q;
    logic  div_busy, div_done, div_sel_reg;
    kabf_out_t out_reg;

    // saturate a W+1 bit sum
    function automatic word_t sat1(input logic signed [W:0] v);
        if (v > $signed({1'b0, WMAX})) begin
            return WMAX;
        end else if (v < $signed({1'b1, WMIN})) begin
            return WMIN;
        end
        return v[W-1:0];
    endfunction

    function automatic word_t sadd(input word_t a, input word_t b);
        return sat1({a[W-1], a} + {b[W-1], b});
    endfunction

    function automatic word_t ssub(input word_t a, input word_t b);
        return sat1({a[W-1], a} - {b[W-1], b});
    endfunction

    function automatic word_t clamp_in(input logic signed [27:0] v);
        logic signed [W+27:0] e;
        e = (W+28)'(v);
        if (e > (W+28)'(WMAX)) begin
            return WMAX;
        end else if (e < (W+28)'(WMIN)) begin
            return WMIN;
        end
        return e[W-1:0];
    endfunction

    function automatic word_t ucfg(input logic [CFG_W-1:0] v);
        logic [W+CFG_W-1:0] e;
        e = (W+CFG_W)'(v);
        if (e > (W+CFG_W)'(WMAX)) begin
            return WMAX;
        end
        return e[W-1:0];
    endfunction

    function automatic word_t scale_dt(input logic [15:0] ts);
        logic [W+39:0] e;
        if (FRAC_BITS >= 16) begin
            e = (W+40)'(ts) << (FRAC_BITS - 16);
        end else begin
            e = (W+40)'(ts) >> (16 - FRAC_BITS);
        end
        if (e > (W+40)'(WMAX)) begin
            return WMAX;
        end
        return e[W-1:0];
    endfunction

    assign qa      = ucfg(qa_cfg);
    assign qb      = ucfg(qb_cfg);
    assign rn      = ucfg(rn_cfg);
    assign meas_in = clamp_in(28'(in_item.measured_angle));
    assign rate_in = clamp_in(in_item.measured_rate);
    assign dt_in   = scale_dt(in_item.time_step);

    // shared multiplier: at most one product per op, registered into t_reg (d_reg in OP_PRED2)
    logic [W-1:0]  ma, mb;
    logic [PW-1:0] mp;
    logic [PW-1:0] mr;
    logic          mneg, msat;
    logic [W:0]    mlim, mmag;
    logic [W:0]    mres;

    always_comb begin
        ma   = mul_a[W-1] ? W'(-mul_a) : W'(mul_a);
        mb   = mul_b[W-1] ? W'(-mul_b) : W'(mul_b);
        mneg = mul_a[W-1] ^ mul_b[W-1];
        mp   = PW'(ma) * PW'(mb);
        mr   = mp >> FRAC_BITS;
        mlim = mneg ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
        msat = (mr > PW'(mlim));
        mmag = msat ? mlim : mr[W:0];
        mres = mneg ? -mmag : mmag;
        mul_r = mres[W-1:0];
    end

    always_comb begin
        mul_a = dt_reg;
        mul_b = rate_reg;
        unique case (cmd.op)
            OP_PRED2: begin mul_a = dt_reg; mul_b = p11_reg; end
            OP_P00B:  begin mul_a = dt_reg; mul_b = t_reg;   end
            OP_P00C:  begin mul_a = qb;     mul_b = dt_reg;  end
            OP_ANG:   begin mul_a = k0_reg; mul_b = y_reg;   end
            OP_ANG2:  begin mul_a = k1_reg; mul_b = y_reg;   end
            OP_BIAS:  begin mul_a = k0_reg; mul_b = p00_reg; end
            OP_C00:   begin mul_a = k0_reg; mul_b = p01_reg; end
            OP_C01:   begin mul_a = k1_reg; mul_b = p00_reg; end
            OP_C10:   begin mul_a = k1_reg; mul_b = p01_reg; end
            default:  begin mul_a = dt_reg; mul_b = rate_reg; end
        endcase
    end

    assign div_num = (cmd.op == OP_DIV1) ? p10_reg : p00_reg;

    kabf_divider #(
        .FRAC_BITS  (FRAC_BITS),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (s_reg),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_q)
    );

    assign status.div_busy = div_busy | cmd.div_start;

    function automatic logic signed [31:0] out32(input word_t v);
        logic signed [W+31:0] e;
        e = (W+32)'(v);
        if (e > (W+32)'(33'sh7FFFFFFF)) begin
            return 32'sh7FFFFFFF;
        end else if (e < -(W+32)'(33'sh80000000)) begin
            return 32'sh80000000;
        end
        return e[31:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg <= '0;
            bias_reg  <= '0;
            p00_reg   <= '0;
            p01_reg   <= '0;
            p10_reg   <= '0;
            p11_reg   <= '0;
        end else begin
            if (div_done) begin
                if (div_sel_reg) begin
                    k1_reg <= (s_reg > 0) ? div_q : '0;
                end else begin
                    k0_reg <= (s_reg > 0) ? div_q : '0;
                end
            end
            if (cmd.div_start) begin
                div_sel_reg <= (cmd.op == OP_DIV1);
            end
            if (cmd.op_valid) begin
                unique case (cmd.op)
                    OP_LOAD: begin
                        meas_reg <= meas_in;
                        dt_reg   <= dt_in;
                        rate_reg <= ssub(rate_in, bias_reg);
                    end
                    OP_PRED:  t_reg <= mul_r;
                    OP_PRED2: begin
                        pred_reg <= sadd(angle_reg, t_reg);
                        d_reg    <= mul_r;
                    end
                    OP_P00A: t_reg <= sadd(ssub(ssub(d_reg, p01_reg), p10_reg), qa);
                    OP_P00B: t_reg <= mul_r;
                    OP_P00C: begin
                        p00_reg <= sadd(p00_reg, t_reg);
                        p01_reg <= ssub(p01_reg, d_reg);
                        p10_reg <= ssub(p10_reg, d_reg);
                        t_reg   <= mul_r;
                    end
                    OP_P11: begin
                        p11_reg <= sadd(p11_reg, t_reg);
                        s_reg   <= sadd(p00_reg, rn);
                    end
                    OP_DIV0, OP_DIV1: ;
                    OP_Y:    y_reg <= ssub(meas_reg, pred_reg);
                    OP_ANG:  t_reg <= mul_r;
                    OP_ANG2: begin
                        angle_reg <= sadd(pred_reg, t_reg);
                        t_reg     <= mul_r;
                    end
                    OP_BIAS: begin
                        bias_reg <= sadd(bias_reg, t_reg);
                        t_reg    <= mul_r;
                    end
                    OP_C00: begin
                        n00_reg <= ssub(p00_reg, t_reg);
                        t_reg   <= mul_r;
                    end
                    OP_C01: begin
                        n01_reg <= ssub(p01_reg, t_reg);
                        t_reg   <= mul_r;
                    end
                    OP_C10: begin
                        n10_reg <= ssub(p10_reg, t_reg);
                        t_reg   <= mul_r;
                    end
                    OP_C11: begin
                        p11_reg <= ssub(p11_reg, t_reg);
                        p00_reg <= n00_reg;
                        p01_reg <= n01_reg;
                        p10_reg <= n10_reg;
                    end
                    default: ;
                endcase
            end
            if (cmd.out_load) begin
                out_reg.filtered_angle <= out32(angle_reg);
                out_reg.rate_bias      <= out32(bias_reg);
            end
        end
    end

    assign out_item = out_reg;
endmodule

// ----- rtl/kabf_ctrl.sv -----
// ----------------------------------------------------------------------------
// kabf_ctrl
// Sequencer: steps the datapath through one filter update per item.
// ----------------------------------------------------------------------------
module kabf_ctrl
    import kabf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  kabf_status_t status,
    output kabf_cmd_t    cmd
);
    kabf_state_t state_reg, state_next;
    kabf_op_t    op_reg, op_next;
    logic        m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_RUN;
                    op_next    = OP_PRED;
                end
            end
            ST_RUN: begin
                if (op_reg == OP_DIV0 || op_reg == OP_DIV1) begin
                    state_next = ST_DIV_WAIT;
                end else if (op_reg == OP_C11) begin
                    state_next = ST_OUT;
                end else begin
                    op_next = kabf_op_t'(op_reg + 1'b1);
                end
            end
            ST_DIV_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_RUN;
                    op_next    = kabf_op_t'(op_reg + 1'b1);
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd           = '0;
        cmd.op        = op_reg;
        s_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.op       = OP_LOAD;
                cmd.op_valid = s_valid;
            end
            ST_RUN: begin
                cmd.op_valid  = 1'b1;
                cmd.div_start = (op_reg == OP_DIV0 || op_reg == OP_DIV1);
            end
            ST_DIV_WAIT: ;
            ST_OUT: cmd.out_load = (!m_valid_reg || m_ready);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_LOAD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
endmodule

// ----- rtl/kalman_angle_bias_filter_core.sv -----
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter_core
// Two-state (angle, gyro bias) Kalman filter, saturating fixed point.
// ----------------------------------------------------------------------------
//  channel   ports                          direction
//  s_        s_valid/s_ready/s_data         in:  angle, rate, time step
//  m_        m_valid/m_ready/m_data         out: filtered angle, bias
//  cfg_      cfg_valid/cfg_ready/idx/data   in:  noise registers
//
//  The bit-serial divider runs twice per item, once for each of the two gains,
//  and the core takes no new item until the update of the last one is done.
//  A finished result sits in the output register; the next item is taken
//  while it waits. Synchronous active-low reset clears the filter state and loads the noise registers with defaults.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter_core
    import kabf_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  kabf_in_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output kabf_out_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    kabf_cmd_t    cmd;
    kabf_status_t status;
    logic [CFG_W-1:0] qa_reg, qb_reg, rn_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qa_reg <= ANGLE_NOISE_RST;
            qb_reg <= BIAS_NOISE_RST;
            rn_reg <= MEAS_NOISE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ANGLE_NOISE: qa_reg <= cfg_data;
                CFG_BIAS_NOISE:  qb_reg <= cfg_data;
                CFG_MEAS_NOISE:  rn_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    kabf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    kabf_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .in_item  (s_data),
        .qa_cfg   (qa_reg),
        .qb_cfg   (qb_reg),
        .rn_cfg   (rn_reg),
        .out_item (m_data)
    );
endmodule

// ----- sim/kalman_angle_bias_filter_core_test.sv -----
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter_core_test
// Self-checking bench for the angle/bias Kalman filter core. A bit-exact
// fixed-point predictor tracks every input transfer; each output transfer is
// compared with the oldest predicted angle/bias pair. Noise registers are
// reprogrammed between phases while the core is idle.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter_core_test;
    import kabf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int NOISE_MAX = 4194304;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    kabf_in_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    kabf_out_t            m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    kalman_angle_bias_filter_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // filter state mirrored by the predictor
    longint est_angle, est_bias, p00, p01, p10, p11;
    longint q_angle, q_bias, r_meas;

    kabf_out_t expected_q[$];
    int        errors;
    int        items_sent;
    int        results_seen;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_cycles;

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic longint sat_word(longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    function automatic longint sat_signed(bit neg, longint unsigned mag);
        longint unsigned lim;
        lim = neg ? longint'(WMAX) + 1 : longint'(WMAX);
        if (mag > lim) mag = lim;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        longint unsigned ma, mb;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        return sat_signed((a < 0) != (b < 0), (ma * mb) >> 16);
    endfunction

    // quotient truncated toward zero; zero divisor never reaches here
    function automatic longint fx_div(longint n, longint d);
        longint unsigned mn, md;
        mn = n < 0 ? -n : n;
        md = d < 0 ? -d : d;
        if (md == 0) return 0;
        return sat_signed((n < 0) != (d < 0), (mn << 16) / md);
    endfunction

    function automatic void reset_filter_model();
        est_angle = 0; est_bias = 0;
        p00 = 0; p01 = 0; p10 = 0; p11 = 0;
        q_angle = longint'(ANGLE_NOISE_RST);
        q_bias  = longint'(BIAS_NOISE_RST);
        r_meas  = longint'(MEAS_NOISE_RST);
    endfunction

    function automatic kabf_out_t filter_step(kabf_in_t it);
        longint meas, dt, rate, pred, dtp11, s, k0, k1, y, p00t, p01t;
        kabf_out_t res;
        meas  = longint'(it.measured_angle);
        dt    = longint'(it.time_step);
        rate  = sat_word(longint'(it.measured_rate) - est_bias);
        pred  = sat_word(est_angle + fx_mul(dt, rate));
        dtp11 = fx_mul(dt, p11);
        p00   = sat_word(p00 + fx_mul(dt,
                    sat_word(sat_word(sat_word(dtp11 - p01) - p10) + q_angle)));
        p01   = sat_word(p01 - dtp11);
        p10   = sat_word(p10 - dtp11);
        p11   = sat_word(p11 + fx_mul(q_bias, dt));
        s     = sat_word(p00 + r_meas);
        // non-positive innovation variance: no correction
        if (s > 0) begin
            k0 = fx_div(p00, s);
            k1 = fx_div(p10, s);
        end else begin
            k0 = 0;
            k1 = 0;
        end
        y         = sat_word(meas - pred);
        est_angle = sat_word(pred + fx_mul(k0, y));
        est_bias  = sat_word(est_bias + fx_mul(k1, y));
        p00t = p00;
        p01t = p01;
        p00  = sat_word(p00 - fx_mul(k0, p00t));
        p01  = sat_word(p01 - fx_mul(k0, p01t));
        p10  = sat_word(p10 - fx_mul(k1, p00t));
        p11  = sat_word(p11 - fx_mul(k1, p01t));
        res.filtered_angle = est_angle[31:0];
        res.rate_bias      = est_bias[31:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // input and config transfers feed the predictor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ANGLE_NOISE: q_angle = longint'(cfg_data);
                    CFG_BIAS_NOISE:  q_bias  = longint'(cfg_data);
                    CFG_MEAS_NOISE:  r_meas  = longint'(cfg_data);
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_q.push_back(filter_step(s_data));
                items_sent++;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        kabf_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = expected_q.pop_front();
                if (m_data.filtered_angle !== want.filtered_angle)
                    report_mismatch($sformatf("filtered_angle got %0d want %0d",
                        m_data.filtered_angle, want.filtered_angle));
                if (m_data.rate_bias !== want.rate_bias)
                    report_mismatch($sformatf("rate_bias got %0d want %0d",
                        m_data.rate_bias, want.rate_bias));
            end
        end
    end

    // receiver: random stalls plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_ready = 1'b0;
        end else begin
            m_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(input kabf_in_t it);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_valid = 1'b1;
        s_data  = it;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic send_fields(input int ang, input int rate, input int ts);
        kabf_in_t it;
        it.measured_angle = 25'(ang);
        it.measured_rate  = 28'(rate);
        it.time_step      = 16'(ts);
        send_item(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_W'(val);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic set_noise(input int qa, input int qb, input int rn);
        wait_drained();
        write_reg(CFG_ANGLE_NOISE, qa);
        write_reg(CFG_BIAS_NOISE, qb);
        write_reg(CFG_MEAS_NOISE, rn);
    endtask

    task automatic random_item(input bit shaped);
        kabf_in_t it;
        if (shaped && $urandom_range(9) != 0) begin
            // plausible sensor stream: small steps, moderate rates
            it.measured_angle = 25'($signed($urandom_range(0, 2 * 5898240)) - 5898240);
            it.measured_rate  = 28'($signed($urandom_range(0, 2 * 13107200)) - 13107200);
            it.time_step      = 16'($urandom_range(1, 3000));
        end else begin
            it.measured_angle = 25'($signed($urandom_range(0, 2 * 11796480)) - 11796480);
            it.measured_rate  = 28'($urandom);
            it.time_step      = 16'($urandom);
        end
        send_item(it);
    endtask

    task automatic test_defaults_and_extremes();
        send_idle_pct = 0; recv_stall_pct = 0;
        send_fields(0, 0, 0);
        send_fields(11796480, 0, 655);
        send_fields(-11796480, 0, 655);
        send_fields(0, 134217727, 65535);
        send_fields(0, -134217728, 65535);
        send_fields(11796480, 134217727, 65535);
        send_fields(-11796480, -134217728, 65535);
        send_fields(-11796480, 134217727, 0);
        send_fields(65536, 65536, 1);
        send_fields(-65536, -65536, 65535);
    endtask

    task automatic test_register_extremes();
        set_noise(NOISE_MAX, NOISE_MAX, NOISE_MAX);
        send_fields(11796480, 134217727, 65535);
        send_fields(-11796480, -134217728, 65535);
        send_fields(1000, -5, 30000);
        // measurement noise of zero makes s equal p00, so any positive p00 gives a unity angle gain
        set_noise(0, 0, 0);
        send_fields(0, 0, 100);
        send_fields(11796480, 65536, 1000);
        send_fields(-11796480, -65536, 65535);
        set_noise(0, NOISE_MAX, 1);
        send_fields(5000, 70000, 65535);
        send_fields(-5000, -70000, 65535);
        // unused index must not disturb the noise registers
        wait_drained();
        write_reg(CFG_UNUSED, 8388607);
        send_fields(65536, 0, 1000);
        send_fields(-65536, 0, 1000);
    endtask

    task automatic test_random_phase(input int sidle, input int rstall, input int n);
        set_noise($urandom_range(0, NOISE_MAX), $urandom_range(0, NOISE_MAX),
                  $urandom_range(1, NOISE_MAX));
        send_idle_pct = sidle; recv_stall_pct = rstall;
        repeat (n) random_item(1'b1);
    endtask

    task automatic test_backpressure();
        wait_drained();
        write_reg(CFG_ANGLE_NOISE, ANGLE_NOISE_RST);
        write_reg(CFG_BIAS_NOISE, BIAS_NOISE_RST);
        write_reg(CFG_MEAS_NOISE, MEAS_NOISE_RST);
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_cycles = 3000;
        repeat (16) random_item(1'b1);
    endtask

    initial begin
        errors = 0; items_sent = 0; results_seen = 0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
        aresetn = 1'b0;
        s_valid = 1'b0; s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        reset_filter_model();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_defaults_and_extremes();
        test_register_extremes();
        test_random_phase(0, 0, 100);
        test_random_phase(75, 0, 100);
        test_random_phase(0, 75, 100);
        test_random_phase(27, 27, 100);
        test_backpressure();

        wait_drained();
        repeat (200) @(negedge aclk);
        $display("Covered %0d input transfers and %0d result transfers over", items_sent,
                 results_seen);
        $display("register extremes, zero measurement noise, idle/stall mixes, long hold-off.");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("Timeout with %0d results outstanding", expected_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/kabf_pkg.sv
rtl/kabf_divider.sv
rtl/kabf_datapath.sv
rtl/kabf_ctrl.sv
rtl/kalman_angle_bias_filter_core.sv
sim/kalman_angle_bias_filter_core_test.sv
